### rtl/ambient_light_backlight_level_top_defines.svh
// assertion macros used by the top-level rtl file
`ifndef AMBIENT_LIGHT_BACKLIGHT_LEVEL_TOP_DEFINES_SVH
`define AMBIENT_LIGHT_BACKLIGHT_LEVEL_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// checked only out of reset
`define ALB_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("%m: assertion failed");
// checked on every edge, reset included
`define ALB_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error("%m: assertion failed");
`else
`define ALB_ASSERT(lbl, prop)
`define ALB_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

### rtl/alb_pkg.sv
package alb_pkg;

  localparam int unsigned READ_W = 12;  // adc reading and average
  localparam int unsigned LVL_W  = 8;   // backlight level
  localparam int unsigned ITV_W  = 16;  // sample interval and tick counter
  localparam int unsigned PROD_W = 20;  // magnitude of (reading span * level span)
  localparam int unsigned DEN_W  = 12;  // divisor: sample count or reading span

  // register indexes on the configuration port
  typedef enum logic [2:0] {
    REG_INTERVAL,
    REG_BRIGHT,
    REG_DARK,
    REG_MAX_LVL,
    REG_MIN_LVL,
    REG_FALLBACK
  } alb_reg_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WIN,
    ST_AVG,
    ST_MAP,
    ST_LVL_GO,
    ST_LVL,
    ST_DONE
  } alb_state_e;

  // window status towards the sequencer
  typedef struct packed {
    logic done;
    logic taken;
    logic have;
  } win_stat_t;

endpackage

### rtl/alb_div.sv
// restoring divider, one quotient bit per cycle
module alb_div import alb_pkg::*; #(
  parameter int unsigned NUM_W = 20
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [NUM_W-1:0] numer_i,
  input  logic [DEN_W-1:0] denom_i,
  output logic             done_o,
  output logic [NUM_W-1:0] quot_o
);

  localparam int unsigned CNT_W = (NUM_W > 1) ? $clog2(NUM_W) : 1;

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [NUM_W-1:0] quo_q;
  logic [DEN_W-1:0] rem_q;
  logic [DEN_W-1:0] den_q;
  logic [DEN_W:0]   trial;
  logic             ge;
  logic [DEN_W:0]   diff;

  always_comb begin
    trial = {rem_q, quo_q[NUM_W-1]};
    ge    = (trial >= {1'b0, den_q});
    diff  = trial - {1'b0, den_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(NUM_W - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // partial remainder stays below the divisor, so DEN_W bits hold it
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= numer_i;
      rem_q <= '0;
      den_q <= denom_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[NUM_W-2:0], ge};
      rem_q <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
    end
  end

  assign done_o = done_q;
  assign quot_o = quo_q;

endmodule

### rtl/alb_window.sv
// sample gate, ring window and running sum
module alb_window import alb_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [READ_W-1:0] reading_i,
  input  logic [ITV_W-1:0]  interval_i,
  output win_stat_t         stat_o,
  output logic [$clog2(WINDOW_LEN*4095+1)-1:0] sum_o,
  output logic [$clog2(WINDOW_LEN+1)-1:0]      count_o
);

  localparam int unsigned SLOT_W = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int unsigned CNT_W  = $clog2(WINDOW_LEN + 1);
  localparam int unsigned SUM_W  = $clog2(WINDOW_LEN * 4095 + 1);

  logic [READ_W-1:0] mem_q [WINDOW_LEN];
  logic [READ_W-1:0] rd_q;
  logic [READ_W-1:0] reading_q;
  logic [SLOT_W-1:0] slot_q;
  logic              full_q;
  logic [SUM_W-1:0]  sum_q;
  logic [ITV_W-1:0]  ticks_q;
  logic              first_q;
  logic              busy_q;
  logic              take_q;
  logic              done_q;
  logic [ITV_W-1:0]  elapsed;
  logic              take;
  logic [SUM_W-1:0]  sub;

  always_comb begin
    elapsed = (ticks_q == '1) ? ticks_q : ticks_q + 1'b1;
    take    = !first_q || (elapsed >= interval_i);
    sub     = full_q ? SUM_W'(rd_q) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q  <= '0;
      full_q  <= 1'b0;
      sum_q   <= '0;
      ticks_q <= '0;
      first_q <= 1'b0;
      busy_q  <= 1'b0;
      take_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      done_q <= busy_q;
      busy_q <= start_i;
      if (start_i) begin
        take_q  <= take;
        first_q <= first_q | take;
        ticks_q <= take ? '0 : elapsed;
      end
      if (busy_q && take_q) begin
        sum_q <= sum_q - sub + SUM_W'(reading_q);
        if (slot_q == SLOT_W'(WINDOW_LEN - 1)) begin
          slot_q <= '0;
          full_q <= 1'b1;
        end else begin
          slot_q <= slot_q + 1'b1;
        end
      end
    end
  end

  // ring memory: oldest entry read on accept, new entry written in the next cycle
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rd_q      <= mem_q[slot_q];
      reading_q <= reading_i;
    end
    if (busy_q && take_q) begin
      mem_q[slot_q] <= reading_q;
    end
  end

  assign stat_o.done  = done_q;
  assign stat_o.taken = take_q;
  assign stat_o.have  = full_q || (slot_q != '0);
  assign sum_o        = sum_q;
  assign count_o      = full_q ? CNT_W'(WINDOW_LEN) : CNT_W'(slot_q);

endmodule

### rtl/ambient_light_backlight_level_top.sv
// sequence: one word at a time, averaged and then mapped by two passes of the bit-serial
//   divider; equal bounds skip the second pass, and an empty window skips both
// flow: the next word is taken once the result sits in the output register, which then
//   waits for the sink on its own
// reset: rst_ni is asynchronous, active low; it empties the window, clears the tick
//   counter and loads the register defaults; window entries are not cleared
`include "ambient_light_backlight_level_top_defines.svh"

module ambient_light_backlight_level_top import alb_pkg::*; #(
  parameter int unsigned WINDOW_LEN = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [11:0] adc_reading, [15:12] zero
  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] sample_taken, [1] have_samples,
                                      // [13:2] avg_reading, [21:14] backlight_level,
                                      // [23:22] zero
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int unsigned SUM_W = $clog2(WINDOW_LEN * 4095 + 1);
  localparam int unsigned CNT_W = $clog2(WINDOW_LEN + 1);
  // one divider serves the average and the level map, sized for the wider one
  localparam int unsigned NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;

  // configuration registers
  logic [ITV_W-1:0]  interval_q;
  logic [READ_W-1:0] bright_q;
  logic [READ_W-1:0] dark_q;
  logic [LVL_W-1:0]  max_q;
  logic [LVL_W-1:0]  min_q;
  logic [LVL_W-1:0]  fallback_q;

  alb_state_e state_q, state_d;

  logic              accept;
  logic              div_start;
  logic              out_free;
  logic              load_out;

  win_stat_t         win_stat;
  logic [SUM_W-1:0]  win_sum;
  logic [CNT_W-1:0]  win_cnt;

  logic [NUM_W-1:0]  div_numer;
  logic [DEN_W-1:0]  div_denom;
  logic              div_done;
  logic [NUM_W-1:0]  div_quot;

  // datapath registers
  logic [READ_W-1:0] avg_q;
  logic [LVL_W-1:0]  level_q;
  logic signed [21:0] prod_q;
  logic              neg_q;
  logic [DEN_W-1:0]  dmag_q;

  // level map terms
  logic [READ_W-1:0] raw_lo;
  logic [READ_W-1:0] raw_cl;
  logic signed [12:0] diff_s;
  logic signed [8:0]  span_s;
  logic signed [12:0] dspan_s;
  logic signed [21:0] prod_s;
  logic [12:0]        dmag;
  logic [21:0]        pmag;
  logic signed [9:0]  qs;
  logic signed [9:0]  lvl_s;
  logic [LVL_W-1:0]   lvl_cl;

  logic [23:0]        out_q;
  logic               out_vld_q;

  // ---------------------------------------------------------------- register port
  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= ITV_W'(100);
      bright_q   <= READ_W'(200);
      dark_q     <= READ_W'(3500);
      max_q      <= LVL_W'(255);
      min_q      <= LVL_W'(10);
      fallback_q <= LVL_W'(128);
    end else if (psel && penable && pwrite) begin
      case (paddr[4:2])
        REG_INTERVAL: interval_q <= pwdata[ITV_W-1:0];
        REG_BRIGHT:   bright_q   <= pwdata[READ_W-1:0];
        REG_DARK:     dark_q     <= pwdata[READ_W-1:0];
        REG_MAX_LVL:  max_q      <= pwdata[LVL_W-1:0];
        REG_MIN_LVL:  min_q      <= pwdata[LVL_W-1:0];
        REG_FALLBACK: fallback_q <= pwdata[LVL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_INTERVAL: prdata = 32'(interval_q);
      REG_BRIGHT:   prdata = 32'(bright_q);
      REG_DARK:     prdata = 32'(dark_q);
      REG_MAX_LVL:  prdata = 32'(max_q);
      REG_MIN_LVL:  prdata = 32'(min_q);
      REG_FALLBACK: prdata = 32'(fallback_q);
      default:      prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------- window and divider
  assign accept = s_axis_tvalid && s_axis_tready;

  alb_window #(
    .WINDOW_LEN (WINDOW_LEN)
  ) u_window (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (accept),
    .reading_i  (s_axis_tdata[READ_W-1:0]),
    .interval_i (interval_q),
    .stat_o     (win_stat),
    .sum_o      (win_sum),
    .count_o    (win_cnt)
  );

  // average pass divides the sum by the count, map pass the product by the reading span
  always_comb begin
    if (state_q == ST_LVL_GO) begin
      div_numer = NUM_W'(pmag[PROD_W-1:0]);
      div_denom = dmag_q;
    end else begin
      div_numer = NUM_W'(win_sum);
      div_denom = DEN_W'(win_cnt);
    end
  end

  alb_div #(
    .NUM_W (NUM_W)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .numer_i (div_numer),
    .denom_i (div_denom),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // ---------------------------------------------------------------- sequencer
  assign out_free = !out_vld_q || m_axis_tready;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_WIN;
      ST_WIN: begin
        if (win_stat.done) begin
          state_d = win_stat.have ? ST_AVG : ST_DONE;
        end
      end
      ST_AVG:    if (div_done) state_d = ST_MAP;
      ST_MAP:    state_d = (dspan_s == '0) ? ST_DONE : ST_LVL_GO;
      ST_LVL_GO: state_d = ST_LVL;
      ST_LVL:    if (div_done) state_d = ST_DONE;
      ST_DONE:   if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    div_start     = 1'b0;
    load_out      = 1'b0;
    case (state_q)
      ST_WIN:    div_start = win_stat.done && win_stat.have;
      ST_LVL_GO: div_start = 1'b1;
      ST_DONE:   load_out  = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // ---------------------------------------------------------------- level map
  // clamp up to the bright bound first, then down to the dark bound
  always_comb begin
    raw_lo  = (avg_q < bright_q) ? bright_q : avg_q;
    raw_cl  = (raw_lo > dark_q) ? dark_q : raw_lo;
    diff_s  = $signed({1'b0, raw_cl}) - $signed({1'b0, bright_q});
    span_s  = $signed({1'b0, min_q}) - $signed({1'b0, max_q});
    dspan_s = $signed({1'b0, dark_q}) - $signed({1'b0, bright_q});
    prod_s  = diff_s * span_s;
    dmag    = dspan_s[12] ? 13'(-dspan_s) : 13'(dspan_s);
    pmag    = prod_q[21] ? 22'(-prod_q) : 22'(prod_q);
  end

  // signed quotient truncates toward zero: divide magnitudes, then restore the sign;
  // lower clamp to min first so that max wins when the bounds cross
  always_comb begin
    qs     = neg_q ? -$signed({2'b00, div_quot[LVL_W-1:0]})
                   : $signed({2'b00, div_quot[LVL_W-1:0]});
    lvl_s  = qs + $signed({2'b00, max_q});
    lvl_cl = max_q;
    if (lvl_s < $signed({2'b00, min_q})) begin
      lvl_cl = min_q;
    end else if (lvl_s <= $signed({2'b00, max_q})) begin
      lvl_cl = lvl_s[LVL_W-1:0];
    end
    if (min_q > max_q) begin
      if (lvl_s < $signed({2'b00, min_q})) lvl_cl = max_q;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      ST_WIN: begin
        if (win_stat.done && !win_stat.have) begin
          avg_q   <= '0;
          level_q <= fallback_q;
        end
      end
      ST_AVG: if (div_done) avg_q <= div_quot[READ_W-1:0];
      ST_MAP: begin
        prod_q  <= prod_s;
        neg_q   <= diff_s[12] ^ span_s[8] ^ dspan_s[12];
        dmag_q  <= dmag[DEN_W-1:0];
        level_q <= max_q;
      end
      ST_LVL: if (div_done) level_q <= lvl_cl;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= {2'b00, level_q, avg_q, win_stat.have, win_stat.taken};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  // ---------------------------------------------------------------- checks
  `ALB_ASSERT(a_div_done_in_wait, div_done |-> (state_q == ST_AVG || state_q == ST_LVL))
  `ALB_ASSERT(a_win_done_in_win, win_stat.done |-> (state_q == ST_WIN))
  `ALB_ASSERT(a_accept_starts_win, accept |=> (state_q == ST_WIN))
  `ALB_ASSERT(a_load_gives_valid, load_out |=> m_axis_tvalid)

endmodule
